// File: sv/xse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML string escaper package
// Shared types, character codes and entity name tables for the escaper.
// ----------------------------------------------------------------------------
package xse_pkg;

  // Widest entity value (wrapped high surrogate) fits in 23 bits, 7 digits.
  localparam int VAL_W = 23;
  localparam int DIG_N = 7;
  localparam int BCD_W = 4 * DIG_N;
  localparam int CNT_W = 5;
  localparam int JOB_N = 4;

  // Character codes.
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Named entity strings, right aligned.
  localparam logic [47:0] STR_AMP  = {8'h00, "&amp;"};
  localparam logic [47:0] STR_LT   = {16'h0000, "&lt;"};
  localparam logic [47:0] STR_GT   = {16'h0000, "&gt;"};
  localparam logic [47:0] STR_QUOT = "&quot;";
  localparam logic [47:0] STR_APOS = "&apos;";

  // Surrogate offsets.
  localparam logic [VAL_W-1:0] HI_BASE   = 23'h00D800;
  localparam logic [5:0]       LO_PREFIX = 6'h37;
  localparam logic [21:0]      PLANE_OFS = 22'd64;

  typedef enum logic [2:0] {
    NM_AMP  = 3'd0,
    NM_LT   = 3'd1,
    NM_GT   = 3'd2,
    NM_QUOT = 3'd3,
    NM_APOS = 3'd4
  } name_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_NEXT  = 8'b00000010,
    ST_NAMED = 8'b00000100,
    ST_AMP   = 8'b00001000,
    ST_HASH  = 8'b00010000,
    ST_WAIT  = 8'b00100000,
    ST_DIG   = 8'b01000000,
    ST_SEMI  = 8'b10000000
  } state_t;

  // List of output items for one input word: numeric entities or bytes.
  typedef struct packed {
    logic [JOB_N-1:0][VAL_W-1:0] val;
    logic [JOB_N-1:0]            num;
    logic [2:0]                  cnt;
    logic                        last;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] value;
  } bcd_req_t;

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } bcd_rsp_t;

  function automatic logic is_named(input logic [7:0] b);
    case (b)
      CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic name_t name_of(input logic [7:0] b);
    case (b)
      CH_AMP:  return NM_AMP;
      CH_LT:   return NM_LT;
      CH_GT:   return NM_GT;
      CH_QUOT: return NM_QUOT;
      CH_APOS: return NM_APOS;
      default: return NM_AMP;
    endcase
  endfunction

  function automatic logic [2:0] name_len(input name_t n);
    case (n)
      NM_AMP:  return 3'd5;
      NM_LT:   return 3'd4;
      NM_GT:   return 3'd4;
      NM_QUOT: return 3'd6;
      NM_APOS: return 3'd6;
      default: return 3'd4;
    endcase
  endfunction

  // Character at position pos (from the first) of a named entity.
  function automatic logic [7:0] name_char(input name_t n, input logic [2:0] pos);
    logic [47:0] s;
    int          sh;
    case (n)
      NM_AMP:  s = STR_AMP;
      NM_LT:   s = STR_LT;
      NM_GT:   s = STR_GT;
      NM_QUOT: s = STR_QUOT;
      NM_APOS: s = STR_APOS;
      default: s = STR_AMP;
    endcase
    sh = 8 * (int'(name_len(n)) - 1 - int'(pos));
    if (sh < 0) begin
      sh = 0;
    end
    return s[sh +: 8];
  endfunction

endpackage

// File: sv/xml_string_escaper.sv
`timescale 1ns / 1ps
// Each word is accepted while the formatter is idle; input waits until the last item is sent.
// A plain byte item goes from the item list to the output register once the output can
// take it. A named entity item sends each of its characters in turn.
// A numeric entity sends & and #, waits for the serial converter, then its digits and ;.
// Held lead bytes give no word. Output stalls hold back the item being sent.
// Reset clears the held count, the sequencer and the output valid; held bytes keep data.
// ----------------------------------------------------------------------------
// XML string escaper
// Turns a UTF-8 byte stream into XML-escaped text, holding up to three bytes
// of a multi-byte sequence until it is complete.
// ----------------------------------------------------------------------------
module xml_string_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // out_run_end
  output logic [0:0] m_tuser    // [0] out_string_end
);

  logic [7:0] pend [3];
  logic [1:0] pend_cnt;
  logic       pend_four;

  logic              accept;
  logic              hold;
  logic              lead3;
  logic              lead4;
  logic              complete;
  logic [20:0]       cp4;
  logic [15:0]       cp3;
  logic [21:0]       hi_off;
  xse_pkg::job_t     job;
  logic              job_ready;
  xse_pkg::bcd_req_t bcd_req;
  xse_pkg::bcd_rsp_t bcd_rsp;

  assign s_tready = job_ready;
  assign accept   = s_tvalid && s_tready;

  // Decide what an incoming word does: held, or a list of output items.
  always_comb begin
    lead3    = (s_tdata[7:4] == 4'hE);
    lead4    = (s_tdata[7:3] == 5'b11110);
    complete = pend_four ? (pend_cnt >= 2'd3) : (pend_cnt >= 2'd2);
    cp4      = {pend[0][2:0], pend[1][5:0], pend[2][5:0], s_tdata[5:0]};
    cp3      = {pend[0][3:0], pend[1][5:0], s_tdata[5:0]};
    hi_off   = {11'd0, cp4[20:10]} - xse_pkg::PLANE_OFS;
    hold     = 1'b0;
    for (int i = 0; i < xse_pkg::JOB_N; i++) begin
      job.val[i] = {15'd0, s_tdata};
    end
    job.num  = '0;
    job.cnt  = 3'd1;
    job.last = s_tlast;
    if (pend_cnt == 2'd0) begin
      hold = (lead3 || lead4) && !s_tlast;
    end else if (complete) begin
      if (pend_four) begin
        job.val[0] = {1'b0, hi_off} + xse_pkg::HI_BASE;
        job.val[1] = {7'd0, xse_pkg::LO_PREFIX, cp4[9:0]};
        job.num    = 4'b0011;
        job.cnt    = 3'd2;
      end else begin
        job.val[0] = {7'd0, cp3};
        job.num    = 4'b0001;
      end
    end else if (s_tlast) begin
      // Cut short: held bytes and this byte each get the single-byte rules.
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pend_cnt) begin
          job.val[i] = {15'd0, pend[i]};
        end
      end
      job.cnt = {1'b0, pend_cnt} + 3'd1;
    end else begin
      hold = 1'b1;
    end
  end

  // Held sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt  <= '0;
      pend_four <= 1'b0;
    end else if (accept) begin
      if (hold) begin
        pend_cnt <= pend_cnt + 2'd1;
        if (pend_cnt == 2'd0) begin
          pend_four <= lead4;
        end
      end else begin
        pend_cnt  <= '0;
        pend_four <= 1'b0;
      end
    end
  end

  // Held bytes.
  always_ff @(posedge clk) begin
    if (accept && hold) begin
      pend[pend_cnt] <= s_tdata;
    end
  end

  xse_fmt u_fmt (
    .clk       (clk),
    .rst       (rst),
    .job_valid (accept && !hold),
    .job       (job),
    .ready     (job_ready),
    .bcd_req   (bcd_req),
    .bcd_rsp   (bcd_rsp),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  xse_bcd u_bcd (
    .clk (clk),
    .rst (rst),
    .req (bcd_req),
    .rsp (bcd_rsp)
  );

endmodule

// File: sv/xse_bcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shifts the value in one bit per cycle with add-3 digit correction.
// ----------------------------------------------------------------------------
module xse_bcd (
  input  logic              clk,
  input  logic              rst,
  input  xse_pkg::bcd_req_t req,
  output xse_pkg::bcd_rsp_t rsp
);

  logic [xse_pkg::VAL_W-1:0] bin;
  logic [xse_pkg::BCD_W-1:0] bcd;
  logic [xse_pkg::BCD_W-1:0] adj;
  logic [xse_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic                      done;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < xse_pkg::DIG_N; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // One bit of the binary value moves into the digits each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      bin  <= req.value;
      bcd  <= '0;
      cnt  <= xse_pkg::CNT_W'(xse_pkg::VAL_W);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      bcd <= {adj[xse_pkg::BCD_W-2:0], bin[xse_pkg::VAL_W-1]};
      bin <= {bin[xse_pkg::VAL_W-2:0], 1'b0};
      cnt <= cnt - xse_pkg::CNT_W'(1);
      if (cnt == xse_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.bcd  = bcd;

endmodule

// File: sv/xse_fmt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape formatter
// Walks the item list of one input word and sends the escaped bytes through
// the output register; a new word is taken only once its last item is sent.
// ----------------------------------------------------------------------------
module xse_fmt (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  xse_pkg::job_t     job,
  output logic              ready,
  output xse_pkg::bcd_req_t bcd_req,
  input  xse_pkg::bcd_rsp_t bcd_rsp,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast,   // out_run_end
  output logic [0:0]        m_tuser    // [0] out_string_end
);

  xse_pkg::state_t state;
  xse_pkg::state_t state_next;

  logic [xse_pkg::JOB_N-1:0][xse_pkg::VAL_W-1:0] q_val;
  logic [xse_pkg::JOB_N-1:0]                     q_num;
  logic [2:0]                                    q_cnt;
  logic                                          q_last;
  xse_pkg::name_t                                nm;
  logic [2:0]                                    pos;
  logic [2:0]                                    dig_pos;
  logic [2:0]                                    lead_pos;

  logic       can_emit;
  logic       emit;
  logic       emit_final;
  logic [7:0] emit_byte;
  logic       pop;
  logic       load_named;
  logic [7:0] hb;

  assign can_emit = !m_tvalid || m_tready;
  assign ready    = (state == xse_pkg::ST_IDLE);
  assign hb       = q_val[0][7:0];

  // Highest nonzero digit; a value of zero prints a single digit.
  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < xse_pkg::DIG_N; i++) begin
      if (bcd_rsp.bcd[4*i +: 4] != 4'd0) begin
        lead_pos = 3'(i);
      end
    end
  end

  // Sequencer: decides the next byte and when an item is finished.
  always_comb begin
    state_next    = state;
    emit          = 1'b0;
    emit_final    = 1'b0;
    emit_byte     = hb;
    pop           = 1'b0;
    load_named    = 1'b0;
    bcd_req.start = 1'b0;
    bcd_req.value = q_val[0];
    case (state)
      xse_pkg::ST_IDLE: begin
        if (job_valid) begin
          state_next = xse_pkg::ST_NEXT;
        end
      end
      xse_pkg::ST_NEXT: begin
        if (q_num[0] || (!xse_pkg::is_named(hb) && hb < xse_pkg::CH_SPACE)) begin
          bcd_req.start = 1'b1;
          state_next    = xse_pkg::ST_AMP;
        end else if (xse_pkg::is_named(hb)) begin
          load_named = 1'b1;
          state_next = xse_pkg::ST_NAMED;
        end else if (can_emit) begin
          emit       = 1'b1;
          emit_final = 1'b1;
          pop        = 1'b1;
        end
      end
      xse_pkg::ST_NAMED: begin
        emit_byte = xse_pkg::name_char(nm, pos);
        if (can_emit) begin
          emit = 1'b1;
          if (pos == xse_pkg::name_len(nm) - 3'd1) begin
            emit_final = 1'b1;
            pop        = 1'b1;
          end
        end
      end
      xse_pkg::ST_AMP: begin
        emit_byte = xse_pkg::CH_AMP;
        if (can_emit) begin
          emit       = 1'b1;
          state_next = xse_pkg::ST_HASH;
        end
      end
      xse_pkg::ST_HASH: begin
        emit_byte = xse_pkg::CH_HASH;
        if (can_emit) begin
          emit       = 1'b1;
          state_next = xse_pkg::ST_WAIT;
        end
      end
      xse_pkg::ST_WAIT: begin
        if (bcd_rsp.done) begin
          state_next = xse_pkg::ST_DIG;
        end
      end
      xse_pkg::ST_DIG: begin
        emit_byte = xse_pkg::CH_ZERO + {4'd0, bcd_rsp.bcd[4*dig_pos +: 4]};
        if (can_emit) begin
          emit = 1'b1;
          if (dig_pos == 3'd0) begin
            state_next = xse_pkg::ST_SEMI;
          end
        end
      end
      xse_pkg::ST_SEMI: begin
        emit_byte = xse_pkg::CH_SEMI;
        if (can_emit) begin
          emit       = 1'b1;
          emit_final = 1'b1;
          pop        = 1'b1;
        end
      end
      default: begin
        state_next = xse_pkg::ST_IDLE;
      end
    endcase
    // A finished item moves the list on, or ends the word.
    if (pop) begin
      state_next = (q_cnt == 3'd1) ? xse_pkg::ST_IDLE : xse_pkg::ST_NEXT;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= xse_pkg::ST_IDLE;
      q_cnt    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == xse_pkg::ST_IDLE && job_valid) begin
        q_cnt <= job.cnt;
      end else if (pop) begin
        q_cnt <= q_cnt - 3'd1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item list, entity counters and output word.
  always_ff @(posedge clk) begin
    if (state == xse_pkg::ST_IDLE && job_valid) begin
      q_val  <= job.val;
      q_num  <= job.num;
      q_last <= job.last;
    end else if (pop) begin
      for (int i = 0; i < xse_pkg::JOB_N - 1; i++) begin
        q_val[i] <= q_val[i+1];
      end
      q_num <= q_num >> 1;
    end
    if (load_named) begin
      nm  <= xse_pkg::name_of(hb);
      pos <= '0;
    end else if (state == xse_pkg::ST_NAMED && emit) begin
      pos <= pos + 3'd1;
    end
    if (state == xse_pkg::ST_WAIT) begin
      dig_pos <= lead_pos;
    end else if (state == xse_pkg::ST_DIG && emit) begin
      dig_pos <= dig_pos - 3'd1;
    end
    if (emit) begin
      m_tdata    <= emit_byte;
      m_tlast    <= emit_final && (q_cnt == 3'd1);
      m_tuser[0] <= emit_final && (q_cnt == 3'd1) && q_last;
    end
  end

endmodule
